FILE: design/gla_pkg.sv
// ----------------------------------------------------------------------------
// gla_pkg: shared types and constants for the graph level assigner
// Item layouts, command and state codes, and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package gla_pkg;

  localparam int NODE_W  = 6;
  localparam int LEVEL_W = 6;
  localparam int DEPTH_W = 7;
  localparam int KIND_W  = 2;
  localparam int EDGE_W  = 2 * NODE_W;

  localparam int DEF_MAX_NODES = 64;
  localparam int DEF_MAX_EDGES = 256;

  localparam int QUEUE_DEPTH = 4;
  localparam int QAW         = $clog2(QUEUE_DEPTH);
  localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

  localparam logic [KIND_W-1:0] KIND_NODE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EDGE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_GO   = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              has_records;
    logic [NODE_W-1:0] src_node;
    logic [NODE_W-1:0] dst_node;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0]  node_index;
    logic               node_valid;
    logic [LEVEL_W-1:0] level;
    logic [DEPTH_W-1:0] depth;
    logic               overflow;
    logic               last;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_NODE,
    OP_EDGE,
    OP_GO
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t           op;
    logic              has_records;
    logic [NODE_W-1:0] src_node;
    logic [NODE_W-1:0] dst_node;
  } cmd_t;

  typedef struct packed {
    logic               ranked;
    logic [LEVEL_W-1:0] level;
  } node_ent_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE_RD,
    ST_NODE_RD,
    ST_RELAX,
    ST_PASS_END,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } back_state_t;

endpackage

`default_nettype wire

FILE: design/gla_front.sv
// ----------------------------------------------------------------------------
// gla_front: input side of the graph level assigner
// Accepts items, classifies them into commands and queues them for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module gla_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  output logic                 full,
  input  wire gla_pkg::in_item_t in_item,
  output gla_pkg::cmd_t        q_cmd,
  output logic                 q_empty,
  input  wire logic            q_pop
);
  import gla_pkg::*;

  cmd_t           fifo_r [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  cmd_t           cmd;
  logic           cmd_valid;
  logic           wr_en;
  logic           rd_en;

  always_comb begin
    cmd.has_records = in_item.has_records;
    cmd.src_node    = in_item.src_node;
    cmd.dst_node    = in_item.dst_node;
    cmd.op          = OP_NODE;
    cmd_valid       = 1'b1;
    case (in_item.kind)
      KIND_NODE: cmd.op = OP_NODE;
      KIND_EDGE: cmd.op = OP_EDGE;
      KIND_GO:   cmd.op = OP_GO;
      default:   cmd_valid = 1'b0;
    endcase
  end

  assign full    = (cnt_r == QCW'(QUEUE_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign q_cmd   = fifo_r[rd_ptr_r];
  assign wr_en   = push && !full && cmd_valid;
  assign rd_en   = q_pop && !q_empty;

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + QAW'(1) : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + QAW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + QCW'(1);
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fifo_r[wr_ptr_r] <= cmd;
    end
  end

endmodule

`default_nettype wire

FILE: design/gla_back.sv
// ----------------------------------------------------------------------------
// gla_back: execution side of the graph level assigner
// Stores nodes and edges, relaxes levels over repeated edge passes and emits
// one result item per node, or a single item when no node is stored, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gla_back #(
  parameter int MAX_NODES = gla_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES = gla_pkg::DEF_MAX_EDGES
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire gla_pkg::cmd_t      q_cmd,
  input  wire logic               q_empty,
  output logic                    q_pop,
  output gla_pkg::out_item_t      out_item,
  output logic                    empty,
  input  wire logic               pop
);
  import gla_pkg::*;

  localparam int NSLOT = (MAX_NODES < (1 << NODE_W)) ? MAX_NODES : (1 << NODE_W);
  localparam int NIW   = $clog2(NSLOT);
  localparam int NCW   = $clog2(MAX_NODES + 1);
  localparam int PCW   = $clog2(MAX_NODES + 2);
  localparam int EIW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW   = $clog2(MAX_EDGES + 1);
  localparam int CW    = (NCW > NODE_W) ? NCW : NODE_W;

  node_ent_t           node_mem [NSLOT];
  logic [EDGE_W-1:0]   edge_mem [MAX_EDGES];

  back_state_t         state_r, state_nxt;
  logic [NCW-1:0]      node_cnt_r, node_cnt_nxt;
  logic [ECW-1:0]      edge_cnt_r, edge_cnt_nxt;
  logic                ovf_r, ovf_nxt;
  logic [ECW-1:0]      edge_idx_r, edge_idx_nxt;
  logic [PCW-1:0]      pass_r, pass_nxt;
  logic                changed_r, changed_nxt;
  logic [NCW-1:0]      emit_idx_r, emit_idx_nxt;
  logic [LEVEL_W-1:0]  max_lvl_r, max_lvl_nxt;
  logic [NSLOT-1:0]    lvl_vld_r, lvl_vld_nxt;
  logic [NODE_W-1:0]   s_r, s_nxt;
  logic [NODE_W-1:0]   d_r, d_nxt;
  logic                ok_r, ok_nxt;
  out_item_t           out_r, out_nxt;
  logic                out_vld_r, out_vld_nxt;
  logic [EDGE_W-1:0]   edge_q_r;
  node_ent_t           qa_r, qb_r;

  logic                node_we;
  logic [NIW-1:0]      node_wa;
  node_ent_t           node_wd;
  logic                edge_we;
  logic [EIW-1:0]      edge_wa;
  logic [EDGE_W-1:0]   edge_wd;
  logic [NIW-1:0]      rd_a, rd_b;

  logic [NODE_W-1:0]   e_src, e_dst;
  logic [ECW-1:0]      edge_idx_inc;
  logic [NCW-1:0]      emit_idx_inc;
  logic                slot_free;
  logic                emit_last;
  logic                pass_more;
  logic [LEVEL_W-1:0]  lvl_s, lvl_d, lvl_e;
  logic [LEVEL_W:0]    lvl_inc;
  logic                rank_ok;
  logic                relax_hit;
  logic                emit_in;
  logic                cmd_take;

  assign cmd_take     = (state_r == ST_IDLE) && !q_empty;
  assign e_src        = edge_q_r[NODE_W-1:0];
  assign e_dst        = edge_q_r[EDGE_W-1:NODE_W];
  assign edge_idx_inc = edge_idx_r + ECW'(1);
  assign emit_idx_inc = emit_idx_r + NCW'(1);
  assign slot_free    = !out_vld_r || pop;
  assign emit_last    = (node_cnt_r == '0) || (emit_idx_inc == node_cnt_r);
  assign pass_more    = changed_r && (pass_r <= PCW'(node_cnt_r));

  assign lvl_s     = lvl_vld_r[s_r[NIW-1:0]] ? qa_r.level : '0;
  assign lvl_d     = lvl_vld_r[d_r[NIW-1:0]] ? qb_r.level : '0;
  assign lvl_inc   = {1'b0, lvl_s} + (LEVEL_W + 1)'(1);
  assign rank_ok   = qb_r.ranked && (!qa_r.ranked || (s_r < d_r));
  assign relax_hit = ok_r && rank_ok && ({1'b0, lvl_d} < lvl_inc);

  assign emit_in = (CW'(emit_idx_r) < CW'(NSLOT));
  assign lvl_e   = (emit_in && lvl_vld_r[emit_idx_r[NIW-1:0]]) ? qa_r.level : '0;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_take && (q_cmd.op == OP_GO)) begin
          state_nxt = (edge_cnt_r == '0) ? ST_EMIT_RD : ST_EDGE_RD;
        end
      end
      ST_EDGE_RD:  state_nxt = ST_NODE_RD;
      ST_NODE_RD:  state_nxt = ST_RELAX;
      ST_RELAX:    state_nxt = (edge_idx_inc == edge_cnt_r) ? ST_PASS_END : ST_EDGE_RD;
      ST_PASS_END: state_nxt = pass_more ? ST_EDGE_RD : ST_EMIT_RD;
      ST_EMIT_RD:  state_nxt = ST_EMIT_OUT;
      ST_EMIT_OUT: begin
        if (slot_free) begin
          state_nxt = emit_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = cmd_take;
    empty    = !out_vld_r;
    out_item = out_r;
  end

  always_comb begin
    node_cnt_nxt = node_cnt_r;
    edge_cnt_nxt = edge_cnt_r;
    ovf_nxt      = ovf_r;
    edge_idx_nxt = edge_idx_r;
    pass_nxt     = pass_r;
    changed_nxt  = changed_r;
    emit_idx_nxt = emit_idx_r;
    max_lvl_nxt  = max_lvl_r;
    lvl_vld_nxt  = lvl_vld_r;
    s_nxt        = s_r;
    d_nxt        = d_r;
    ok_nxt       = ok_r;
    out_nxt      = out_r;
    out_vld_nxt  = out_vld_r && !pop;
    node_we      = 1'b0;
    node_wa      = node_cnt_r[NIW-1:0];
    node_wd.ranked = q_cmd.has_records;
    node_wd.level  = '0;
    edge_we      = 1'b0;
    edge_wa      = edge_cnt_r[EIW-1:0];
    edge_wd      = {q_cmd.dst_node, q_cmd.src_node};
    rd_a         = emit_idx_r[NIW-1:0];
    rd_b         = emit_idx_r[NIW-1:0];
    case (state_r)
      ST_IDLE: begin
        if (cmd_take) begin
          case (q_cmd.op)
            OP_NODE: begin
              if (node_cnt_r < NCW'(MAX_NODES)) begin
                node_cnt_nxt = node_cnt_r + NCW'(1);
                node_we      = (CW'(node_cnt_r) < CW'(NSLOT));
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            OP_EDGE: begin
              if (edge_cnt_r < ECW'(MAX_EDGES)) begin
                edge_cnt_nxt = edge_cnt_r + ECW'(1);
                edge_we      = 1'b1;
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            OP_GO: begin
              lvl_vld_nxt  = '0;
              max_lvl_nxt  = '0;
              pass_nxt     = PCW'(1);
              changed_nxt  = 1'b0;
              edge_idx_nxt = '0;
              emit_idx_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      ST_NODE_RD: begin
        s_nxt  = e_src;
        d_nxt  = e_dst;
        ok_nxt = (CW'(e_src) < CW'(node_cnt_r)) && (CW'(e_dst) < CW'(node_cnt_r)) &&
                 (e_src != e_dst);
        rd_a   = e_src[NIW-1:0];
        rd_b   = e_dst[NIW-1:0];
      end
      ST_RELAX: begin
        edge_idx_nxt = edge_idx_inc;
        if (relax_hit) begin
          node_we        = 1'b1;
          node_wa        = d_r[NIW-1:0];
          node_wd.ranked = qb_r.ranked;
          node_wd.level  = lvl_inc[LEVEL_W-1:0];
          lvl_vld_nxt[d_r[NIW-1:0]] = 1'b1;
          changed_nxt    = 1'b1;
          if (lvl_inc[LEVEL_W-1:0] > max_lvl_r) begin
            max_lvl_nxt = lvl_inc[LEVEL_W-1:0];
          end
        end
      end
      ST_PASS_END: begin
        if (pass_more) begin
          pass_nxt     = pass_r + PCW'(1);
          changed_nxt  = 1'b0;
          edge_idx_nxt = '0;
        end
      end
      ST_EMIT_OUT: begin
        if (slot_free) begin
          out_nxt.node_index = NODE_W'(emit_idx_r);
          out_nxt.node_valid = (node_cnt_r != '0);
          out_nxt.level      = lvl_e;
          out_nxt.depth      = {1'b0, max_lvl_r} + DEPTH_W'(1);
          out_nxt.overflow   = ovf_r;
          out_nxt.last       = emit_last;
          out_vld_nxt        = 1'b1;
          if (emit_last) begin
            node_cnt_nxt = '0;
            edge_cnt_nxt = '0;
            ovf_nxt      = 1'b0;
          end else begin
            emit_idx_nxt = emit_idx_inc;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      node_cnt_r <= '0;
      edge_cnt_r <= '0;
      ovf_r      <= 1'b0;
      lvl_vld_r  <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      node_cnt_r <= node_cnt_nxt;
      edge_cnt_r <= edge_cnt_nxt;
      ovf_r      <= ovf_nxt;
      lvl_vld_r  <= lvl_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    edge_idx_r <= edge_idx_nxt;
    pass_r     <= pass_nxt;
    changed_r  <= changed_nxt;
    emit_idx_r <= emit_idx_nxt;
    max_lvl_r  <= max_lvl_nxt;
    s_r        <= s_nxt;
    d_r        <= d_nxt;
    ok_r       <= ok_nxt;
    out_r      <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_wa] <= node_wd;
    end
    qa_r <= node_mem[rd_a];
    qb_r <= node_mem[rd_b];
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[edge_wa] <= edge_wd;
    end
    edge_q_r <= edge_mem[edge_idx_r[EIW-1:0]];
  end

endmodule

`default_nettype wire

FILE: design/graph_level_assigner.sv
// ----------------------------------------------------------------------------
// graph_level_assigner: longest-path layering of a small directed graph
// Node and edge loads are taken one per cycle through a four-entry queue while it is not full.
// A go item relaxes levels in repeated passes over the stored edges, then emits a result per node
// (one item for an empty graph); each edge takes an edge read, a source and destination node read
// and, when the level rises, a level update. Reset is synchronous and clears only the state, queue
// pointers and count, node and edge counts, overflow and output valid flags and level valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module graph_level_assigner #(
  parameter int MAX_NODES = gla_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES = gla_pkg::DEF_MAX_EDGES
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  output logic                     full,
  input  wire gla_pkg::in_item_t   in_item,
  output logic                     empty,
  input  wire logic                pop,
  output gla_pkg::out_item_t       out_item
);
  import gla_pkg::*;

  cmd_t q_cmd;
  logic q_empty;
  logic q_pop;

  gla_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .q_cmd   (q_cmd),
    .q_empty (q_empty),
    .q_pop   (q_pop)
  );

  gla_back #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_cmd    (q_cmd),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_item (out_item),
    .empty    (empty),
    .pop      (pop)
  );

endmodule

`default_nettype wire

FILE: tb/sv/tb_graph_level_assigner.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_graph_level_assigner: self-checking bench for the graph level assigner
// Loads node and edge items, issues go items and checks every emitted level
// against a built-in longest-path predictor. Covers the empty graph, self and
// out-of-range edges, unused kinds, node store overflow, a full-depth chain,
// output back-pressure and random graphs under several idle and stall mixes.
// ----------------------------------------------------------------------------

module tb_graph_level_assigner;
  import gla_pkg::*;

  localparam int MAX_N = DEF_MAX_NODES;
  localparam int MAX_E = DEF_MAX_EDGES;
  localparam int IN_W = $bits(in_item_t);
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 200_000;
  localparam int SETTLE_CYCLES = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  in_item_t in_item = '0;
  logic empty;
  logic pop = 1'b0;
  out_item_t out_item;

  bit ranked_m[MAX_N];
  logic [NODE_W-1:0] arc_src_m[MAX_E];
  logic [NODE_W-1:0] arc_dst_m[MAX_E];
  int node_cnt = 0;
  int arc_cnt = 0;
  bit ovf_m = 1'b0;
  out_item_t level_exp_q[$];

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int rx_hold = 0;
  int items_sent = 0;
  int results_checked = 0;
  int graphs_run = 0;
  int errors = 0;
  int quiet_cycles = 0;

  graph_level_assigner DUT (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .full(full),
    .in_item(in_item),
    .empty(empty),
    .pop(pop),
    .out_item(out_item)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic layer_and_expect();
    int lvl[MAX_N];
    int pass;
    bit changed;
    int s;
    int d;
    int rs;
    int rd;
    int depth;
    out_item_t r;
    for (int i = 0; i < MAX_N; i++) lvl[i] = 0;
    pass = 0;
    changed = 1'b1;
    while (changed && pass <= node_cnt) begin
      pass++;
      changed = 1'b0;
      for (int k = 0; k < arc_cnt; k++) begin
        s = int'(arc_src_m[k]);
        d = int'(arc_dst_m[k]);
        if (s >= node_cnt || d >= node_cnt || s == d) continue;
        rs = ranked_m[s] ? s : -1;
        rd = ranked_m[d] ? d : -1;
        if (rs >= rd) continue;
        if (lvl[d] < lvl[s] + 1) begin
          lvl[d] = lvl[s] + 1;
          changed = 1'b1;
        end
      end
    end
    depth = 1;
    for (int i = 0; i < node_cnt; i++) begin
      if (lvl[i] + 1 > depth) depth = lvl[i] + 1;
    end
    if (node_cnt == 0) begin
      r = '0;
      r.depth = DEPTH_W'(1);
      r.overflow = ovf_m;
      r.last = 1'b1;
      level_exp_q.push_back(r);
    end else begin
      for (int i = 0; i < node_cnt; i++) begin
        r = '0;
        r.node_index = NODE_W'(i);
        r.node_valid = 1'b1;
        r.level = LEVEL_W'(lvl[i]);
        r.depth = DEPTH_W'(depth);
        r.overflow = ovf_m;
        r.last = (i + 1 == node_cnt);
        level_exp_q.push_back(r);
      end
    end
    graphs_run++;
    node_cnt = 0;
    arc_cnt = 0;
    ovf_m = 1'b0;
  endtask

  task automatic accept_cmd(input in_item_t it);
    case (it.kind)
      KIND_NODE: begin
        if (node_cnt < MAX_N) begin
          ranked_m[node_cnt] = it.has_records;
          node_cnt++;
        end else begin
          ovf_m = 1'b1;
        end
      end
      KIND_EDGE: begin
        if (arc_cnt < MAX_E) begin
          arc_src_m[arc_cnt] = it.src_node;
          arc_dst_m[arc_cnt] = it.dst_node;
          arc_cnt++;
        end else begin
          ovf_m = 1'b1;
        end
      end
      KIND_GO: layer_and_expect();
      default: ;
    endcase
    if (it.kind != KIND_UNUSED) items_sent++;
  endtask

  task automatic send_item(input in_item_t it);
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
    accept_cmd(it);
  endtask

  task automatic wait_results_done();
    push <= 1'b0;
    while (level_exp_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic in_item_t node_item(input bit rec);
    in_item_t it;
    it.kind = KIND_NODE;
    it.has_records = rec;
    it.src_node = NODE_W'($urandom);
    it.dst_node = NODE_W'($urandom);
    return it;
  endfunction

  function automatic in_item_t arc_item(input logic [NODE_W-1:0] s, input logic [NODE_W-1:0] d);
    in_item_t it;
    it.kind = KIND_EDGE;
    it.has_records = 1'($urandom);
    it.src_node = s;
    it.dst_node = d;
    return it;
  endfunction

  function automatic in_item_t go_item();
    in_item_t it;
    it = IN_W'($urandom);
    it.kind = KIND_GO;
    return it;
  endfunction

  function automatic in_item_t noise_item();
    in_item_t it;
    it = IN_W'($urandom);
    it.kind = KIND_UNUSED;
    return it;
  endfunction

  function automatic in_item_t random_arc(input int n);
    if (n > 0 && $urandom_range(9) != 0) begin
      return arc_item(NODE_W'($urandom_range(n - 1)), NODE_W'($urandom_range(n - 1)));
    end
    return arc_item(NODE_W'($urandom), NODE_W'($urandom));
  endfunction

  task automatic report_field(input string name, input logic [7:0] expv,
                              input logic [7:0] actv);
    errors++;
    $display("%0t: mismatch in %s: expected %0d, actual %0d", $time, name, expv, actv);
  endtask

  task automatic check_result(input out_item_t act);
    out_item_t want;
    if (level_exp_q.size() == 0) begin
      errors++;
      $display("%0t: result with nothing expected: actual %p", $time, act);
      return;
    end
    want = level_exp_q.pop_front();
    results_checked++;
    if (act.node_index !== want.node_index)
      report_field("node_index", 8'(want.node_index), 8'(act.node_index));
    if (act.node_valid !== want.node_valid)
      report_field("node_valid", 8'(want.node_valid), 8'(act.node_valid));
    if (act.level !== want.level)
      report_field("level", 8'(want.level), 8'(act.level));
    if (act.depth !== want.depth)
      report_field("depth", 8'(want.depth), 8'(act.depth));
    if (act.overflow !== want.overflow)
      report_field("overflow", 8'(want.overflow), 8'(act.overflow));
    if (act.last !== want.last)
      report_field("last", 8'(want.last), 8'(act.last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_result(out_item);
      if (rx_hold > 0) begin
        rx_hold = rx_hold - 1;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("graph_level_assigner test failed");
        $finish;
      end
    end
  end

  task automatic test_small_graph();
    in_item_t it;
    send_item(go_item());
    send_item(node_item(1'b1));
    send_item(arc_item(0, 2));
    send_item(node_item(1'b0));
    send_item(node_item(1'b1));
    send_item(arc_item(1, 3));
    send_item(arc_item(2, 3));
    send_item(node_item(1'b1));
    send_item(arc_item(3, 1));
    send_item(arc_item(2, 2));
    send_item(arc_item(0, 63));
    send_item(arc_item(63, 0));
    send_item(arc_item(3, 4));
    it = '1;
    send_item(it);
    send_item(node_item(1'b1));
    send_item(go_item());
    send_item(node_item(1'b0));
    send_item(go_item());
    wait_results_done();
  endtask

  task automatic test_capacity_chain();
    repeat (MAX_N + 1) send_item(node_item(1'b1));
    for (int i = MAX_N - 2; i >= 0; i--) send_item(arc_item(NODE_W'(i), NODE_W'(i + 1)));
    send_item(go_item());
    send_item(go_item());
    wait_results_done();
  endtask

  task automatic send_random_graph();
    int n;
    int nodes_left;
    int arcs_left;
    if ($urandom_range(11) == 0) begin
      n = 0;
    end else if ($urandom_range(9) == 0) begin
      n = $urandom_range(20, 40);
    end else begin
      n = $urandom_range(1, 10);
    end
    nodes_left = n;
    arcs_left = $urandom_range(0, 2 * n + 2);
    while (nodes_left + arcs_left > 0) begin
      if ($urandom_range(19) == 0) send_item(noise_item());
      if (arcs_left == 0 || (nodes_left > 0 && $urandom_range(1) == 0)) begin
        send_item(node_item($urandom_range(3) != 0));
        nodes_left--;
      end else begin
        send_item(random_arc(n));
        arcs_left--;
      end
    end
    send_item(go_item());
  endtask

  task automatic test_back_pressure();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    rx_hold = 1500;
    repeat (8) send_item(node_item($urandom_range(3) != 0));
    repeat (8) send_item(random_arc(8));
    send_item(go_item());
    repeat (8) send_item(node_item(1'b1));
    repeat (4) send_item(random_arc(8));
    send_item(go_item());
    wait_results_done();
  endtask

  task automatic run_random_phase(input int tx_pct, input int rx_pct, input int quota);
    int start;
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    start = items_sent;
    while (items_sent - start < quota) send_random_graph();
    wait_results_done();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_small_graph();
    test_capacity_chain();
    test_back_pressure();
    run_random_phase(0, 0, 15);
    run_random_phase(74, 0, 15);
    run_random_phase(0, 74, 15);
    run_random_phase(18, 18, 15);
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    wait_results_done();
    $display("Ran %0d graphs from %0d load and go items; %0d results checked, %0d mismatches.",
             graphs_run, items_sent, results_checked, errors);
    $display("Included empty graphs, node store overflow, a full-depth chain and output stalls.");
    if (errors == 0) begin
      $display("graph_level_assigner test passed");
    end else begin
      $display("graph_level_assigner test failed");
    end
    $finish;
  end

endmodule
